>>> hdl/rrm_pkg.sv
// Shared types and constants for the ratiometric resistance meter.
// Used by the top level; holds the sequencer state type and fixed field widths.
// No dependencies.
package rrm_pkg;

    // Fixed widths of the item fields and of the internal datapath.
    localparam int SAMPLE_W  = 16;
    localparam int CHAN_W    = 2;
    localparam int REF_W     = 20;
    localparam int RESULT_W  = 32;
    localparam int AMP_W     = 18;   // max - min of one channel
    localparam int DIFF_W    = 19;   // difference of two amplitudes
    localparam int NUM_MAG_W = 17;   // magnitude of a difference
    localparam int PRODUCT_W = NUM_MAG_W + REF_W;
    localparam int CMP_W     = 36;   // room for ten times a result value

    // Channel codes carried in the input tuser.
    localparam logic [CHAN_W-1:0] CH_SOURCE = 2'd0;
    localparam logic [CHAN_W-1:0] CH_CELL   = 2'd1;
    localparam logic [CHAN_W-1:0] CH_OFFSET = 2'd2;

    // Start values of the peak trackers and the register reset value.
    localparam logic signed [SAMPLE_W-1:0] PEAK_START   = -16'sd32767;
    localparam logic signed [SAMPLE_W-1:0] TROUGH_START = 16'sd32767;
    localparam logic [REF_W-1:0]           REF_RESET    = 20'd10000;

    // Step ratio that forces a refill of the average history.
    localparam logic signed [CMP_W-1:0] STEP_RATIO = 36'sd10;

    // Saturation limits of a result value.
    localparam logic signed [RESULT_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [RESULT_W-1:0] SAT_MIN = 32'sh8000_0000;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AMP,
        ST_DIFF,
        ST_MUL,
        ST_LOAD_RATIO,
        ST_DIV_RATIO,
        ST_RAW,
        ST_CMP_A,
        ST_CMP_B,
        ST_UPDATE,
        ST_LOAD_MEAN,
        ST_DIV_MEAN,
        ST_MEAN
    } state_t;

endpackage

>>> hdl/ratiometric_resistance_meter.sv
// Top level of the ratiometric resistance meter: peak trackers, sequencer,
// moving-average history and output register. Uses rrm_pkg and rrm_divider.
//
//  channel | ports                          | contents
//  --------+--------------------------------+------------------------------------
//  input   | s_tvalid s_tready s_tdata ...  | sample, channel (tuser), end_of_burst
//  result  | m_tvalid m_tready m_tdata ...  | filtered, raw, divide_fault, refilled
//  config  | cfg_we cfg_wdata               | reference_resistance
//
// A sample that does not end an offset burst is taken as soon as it is offered.
// The sample that ends an offset burst starts a run on the bit-serial divider,
// which is used once for the ratio (skipped on a zero divisor) and once for
// the mean; DIV_W is 46 at the default parameters. Input is not ready during it.
// The result waits in an output register; a full register stalls only the last
// step of the next run. Reset is synchronous and clears the history and peaks.
module ratiometric_resistance_meter
    import rrm_pkg::*;
#(
    parameter int AVERAGE_LENGTH = 20,
    parameter int FRACTION_BITS  = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input items.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample
    input  logic [1:0]  s_tuser,   // [1:0] channel
    input  logic        s_tlast,   // end_of_burst
    // Result items.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [31:0] filtered_resistance, [63:32] raw_resistance
    output logic [1:0]  m_tuser,   // [0] divide_fault, [1] history_refilled
    // Configuration.
    input  logic        cfg_we,
    input  logic [19:0] cfg_wdata  // reference_resistance
);

    localparam int LEN_W    = $clog2(AVERAGE_LENGTH);
    localparam int SUM_W    = RESULT_W + 1 + LEN_W;
    localparam int MAG_W    = SUM_W - 1;
    localparam int RATIO_DW = PRODUCT_W + FRACTION_BITS + 1;
    localparam int MEAN_DW  = MAG_W + 1;
    localparam int DIV_W    = (RATIO_DW > MEAN_DW) ? RATIO_DW : MEAN_DW;

    localparam logic [DIV_W-1:0] MAX_MAG = DIV_W'(32'h7FFF_FFFF);
    localparam logic [DIV_W-1:0] MIN_MAG = DIV_W'(32'h8000_0000);
    localparam logic signed [SUM_W-1:0] LEN_S = SUM_W'(AVERAGE_LENGTH);

    // Rounds a doubled quotient half away from zero, applies the sign, saturates.
    function automatic logic signed [RESULT_W-1:0] round_sat(
        input logic [DIV_W-1:0] q2,
        input logic             neg
    );
        logic [DIV_W:0]              q;
        logic [DIV_W-1:0]            mag;
        logic signed [RESULT_W-1:0]  res;
        q   = {1'b0, q2} + (DIV_W + 1)'(1);
        mag = q[DIV_W:1];
        if (neg) begin
            if (mag > MIN_MAG) begin
                res = SAT_MIN;
            end else begin
                res = $signed(~mag[RESULT_W-1:0] + 1'b1);
            end
        end else begin
            if (mag > MAX_MAG) begin
                res = SAT_MAX;
            end else begin
                res = $signed(mag[RESULT_W-1:0]);
            end
        end
        return res;
    endfunction

    // Control state.
    state_t                       state_reg, state_next;
    logic [REF_W-1:0]             ref_reg;
    logic signed [SAMPLE_W-1:0]   max_reg [3];
    logic signed [SAMPLE_W-1:0]   min_reg [3];
    logic                         restart_reg [3];
    logic signed [SAMPLE_W-1:0]   max_next [3];
    logic signed [SAMPLE_W-1:0]   min_next [3];
    logic signed [RESULT_W-1:0]   hist_reg [AVERAGE_LENGTH];
    logic signed [SUM_W-1:0]      sum_reg;
    logic                         m_tvalid_reg;

    // Datapath registers.
    logic signed [AMP_W-1:0]      a_src_reg, a_cell_reg, a_off_reg;
    logic signed [DIFF_W-1:0]     num_reg, den_reg;
    logic [PRODUCT_W-1:0]         product_reg;
    logic [NUM_MAG_W-1:0]         den_mag_reg;
    logic                         neg_reg;
    logic                         sum_neg_reg;
    logic signed [RESULT_W-1:0]   raw_reg;
    logic                         fault_reg;
    logic                         refill_reg;
    logic [63:0]                  m_tdata_reg;
    logic [1:0]                   m_tuser_reg;

    // Sequencer outputs.
    logic                         accept;
    logic                         trigger;
    logic                         div_start;
    logic                         out_free;
    logic                         out_load;
    logic [DIV_W-1:0]             div_dividend;

    // Combinational datapath values.
    logic signed [SAMPLE_W-1:0]   sample;
    logic [DIFF_W-1:0]            num_abs, den_abs;
    logic signed [CMP_W-1:0]      old_w, new_w, ten_old, ten_new;
    logic                         new_pos;
    logic [SUM_W-1:0]             sum_abs;
    logic signed [SUM_W-1:0]      raw_ext, old_ext;
    logic                         div_busy, div_done;
    logic [DIV_W-1:0]             div_quotient;

    assign sample  = $signed(s_tdata[SAMPLE_W-1:0]);
    assign accept  = s_tvalid && s_tready;
    assign trigger = accept && s_tlast && (s_tuser == CH_OFFSET);

    // Peak and trough update for the channel of an accepted sample.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            max_next[c] = restart_reg[c] ? PEAK_START : max_reg[c];
            min_next[c] = restart_reg[c] ? TROUGH_START : min_reg[c];
            if (sample > max_next[c]) begin
                max_next[c] = sample;
            end
            if (sample < min_next[c]) begin
                min_next[c] = sample;
            end
        end
    end

    // Magnitudes, wide comparison operands and the running sum magnitude.
    always_comb begin
        num_abs = num_reg[DIFF_W-1] ? DIFF_W'(-num_reg) : DIFF_W'(num_reg);
        den_abs = den_reg[DIFF_W-1] ? DIFF_W'(-den_reg) : DIFF_W'(den_reg);
        old_w   = CMP_W'(hist_reg[AVERAGE_LENGTH-1]);
        new_w   = CMP_W'(raw_reg);
        ten_old = old_w * STEP_RATIO;
        ten_new = new_w * STEP_RATIO;
        new_pos = !raw_reg[RESULT_W-1];
        sum_abs = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        raw_ext = SUM_W'(raw_reg);
        old_ext = SUM_W'(hist_reg[AVERAGE_LENGTH-1]);
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:       if (trigger) state_next = ST_AMP;
            ST_AMP:        state_next = ST_DIFF;
            ST_DIFF:       state_next = ST_MUL;
            ST_MUL:        state_next = (den_reg == '0) ? ST_LOAD_MEAN : ST_LOAD_RATIO;
            ST_LOAD_RATIO: state_next = ST_DIV_RATIO;
            ST_DIV_RATIO:  if (div_done) state_next = ST_RAW;
            ST_RAW:        state_next = ST_CMP_A;
            ST_CMP_A:      state_next = ST_CMP_B;
            ST_CMP_B:      state_next = ST_UPDATE;
            ST_UPDATE:     state_next = ST_LOAD_MEAN;
            ST_LOAD_MEAN:  state_next = ST_DIV_MEAN;
            ST_DIV_MEAN:   if (div_done) state_next = ST_MEAN;
            ST_MEAN:       if (out_free) state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        s_tready     = (state_reg == ST_IDLE);
        out_free     = !m_tvalid_reg || m_tready;
        out_load     = (state_reg == ST_MEAN) && out_free;
        div_start    = (state_reg == ST_LOAD_RATIO) || (state_reg == ST_LOAD_MEAN);
        div_dividend = (state_reg == ST_LOAD_MEAN)
                     ? (DIV_W'(sum_abs[MAG_W-1:0]) << 1)
                     : (DIV_W'(product_reg) << (FRACTION_BITS + 1));
    end

    // Shared divider: ratio by the source minus offset amplitude, then mean by the length.
    rrm_divider #(
        .DIVIDEND_W (DIV_W),
        .DIVISOR_W  (NUM_MAG_W)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  ((state_reg == ST_LOAD_MEAN) ? NUM_MAG_W'(AVERAGE_LENGTH) : den_mag_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Control state with reset: sequencer, register, peaks, history and valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ref_reg      <= REF_RESET;
            sum_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            for (int c = 0; c < 3; c++) begin
                max_reg[c]     <= PEAK_START;
                min_reg[c]     <= TROUGH_START;
                restart_reg[c] <= 1'b0;
            end
            for (int i = 0; i < AVERAGE_LENGTH; i++) begin
                hist_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                ref_reg <= cfg_wdata;
            end
            // Track peaks of the accepted sample's channel; channel three is ignored.
            if (accept) begin
                for (int c = 0; c < 3; c++) begin
                    if (s_tuser == CHAN_W'(c)) begin
                        max_reg[c]     <= max_next[c];
                        min_reg[c]     <= min_next[c];
                        restart_reg[c] <= s_tlast;
                    end
                end
            end
            // Refill or shift the history, keeping the running sum exact.
            if (state_reg == ST_UPDATE) begin
                if (refill_reg) begin
                    for (int i = 0; i < AVERAGE_LENGTH; i++) begin
                        hist_reg[i] <= raw_reg;
                    end
                    sum_reg <= raw_ext * LEN_S;
                end else begin
                    hist_reg[0] <= raw_reg;
                    for (int i = 1; i < AVERAGE_LENGTH; i++) begin
                        hist_reg[i] <= hist_reg[i-1];
                    end
                    sum_reg <= sum_reg - old_ext + raw_ext;
                end
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers, loaded by sequencer state.
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_AMP: begin
                a_src_reg  <= AMP_W'(max_reg[CH_SOURCE]) - AMP_W'(min_reg[CH_SOURCE]);
                a_cell_reg <= AMP_W'(max_reg[CH_CELL]) - AMP_W'(min_reg[CH_CELL]);
                a_off_reg  <= AMP_W'(max_reg[CH_OFFSET]) - AMP_W'(min_reg[CH_OFFSET]);
            end
            ST_DIFF: begin
                num_reg <= DIFF_W'(a_cell_reg) - DIFF_W'(a_off_reg);
                den_reg <= DIFF_W'(a_src_reg) - DIFF_W'(a_off_reg);
            end
            ST_MUL: begin
                product_reg <= num_abs[NUM_MAG_W-1:0] * ref_reg;
                den_mag_reg <= den_abs[NUM_MAG_W-1:0];
                neg_reg     <= num_reg[DIFF_W-1] != den_reg[DIFF_W-1];
                fault_reg   <= (den_reg == '0);
                refill_reg  <= 1'b0;
                raw_reg     <= '0;
            end
            ST_RAW: begin
                raw_reg <= round_sat(div_quotient, neg_reg);
            end
            // Zero values and oldest against ten times the new value.
            ST_CMP_A: begin
                refill_reg <= (old_w == '0) || (new_w == '0)
                           || (new_pos ? (old_w > ten_new) : (old_w < ten_new));
            end
            // Ten times the oldest against the new value.
            ST_CMP_B: begin
                refill_reg <= refill_reg
                           || (new_pos ? (ten_old < new_w) : (ten_old > new_w));
            end
            ST_LOAD_MEAN: begin
                sum_neg_reg <= sum_reg[SUM_W-1];
            end
            ST_MEAN: begin
                if (out_free) begin
                    m_tdata_reg <= {raw_reg, round_sat(div_quotient, sum_neg_reg)};
                    m_tuser_reg <= {refill_reg, fault_reg};
                end
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // A zero divisor gives a zero raw value and never a refill.
    a_fault_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && (m_tdata[63:32] != 32'd0 || m_tuser[1])))
        else $error("divide fault item carries a raw value or a refill");

    // The item that ends an offset burst closes the input for the computation.
    a_trigger_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        trigger |=> !s_tready)
        else $error("input ready right after a measurement trigger");

    // A division is only started on an idle divider.
    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider started while still busy");

endmodule

>>> hdl/rrm_divider.sv
// Bit-serial restoring divider shared by the ratio and the mean computations.
// Produces one quotient bit per cycle; standalone, no package needed.
module rrm_divider #(
    parameter int DIVIDEND_W = 46,
    parameter int DIVISOR_W  = 17
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  busy,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  div_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    // One restoring step: shift in the next dividend bit and try a subtract.
    always_comb begin
        trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff  = trial - {1'b0, div_reg};
        fits  = (trial >= {1'b0, div_reg});
    end

    // Step counter and status flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else if (start) begin
            cnt_reg  <= CNT_W'(DIVIDEND_W);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    // Partial remainder and quotient shift register.
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
            rem_reg <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

    // The last step always ends the run with a done pulse.
    a_last_step_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && !start && cnt_reg == CNT_W'(1)) |=> (done_reg && !busy_reg))
        else $error("divider did not finish after its last step");

    // A start loads the full step count.
    a_start_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> (busy_reg && cnt_reg == CNT_W'(DIVIDEND_W)))
        else $error("divider start did not load the step count");

    // Done is a single-cycle pulse that never overlaps a busy run.
    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (!busy_reg ##1 !done_reg))
        else $error("divider done was not a single pulse");

endmodule

>>> bench/tb_ratiometric_resistance_meter.sv
// Self-checking bench for the ratiometric resistance meter: a directed set of
// bursts, then randomized measurement bursts under several reference values and
// handshake stall patterns. Depends on rrm_pkg and the ratiometric_resistance_meter RTL.
module tb_ratiometric_resistance_meter
    import rrm_pkg::*;
();

    localparam int HIST_DEPTH      = 20;
    localparam int FRAC_BITS       = 8;
    localparam int ITEMS_PER_PHASE = 160;
    localparam int PHASE_COUNT     = 8;
    localparam int SETTLE_CYCLES   = 150;     // longer than one divide run
    localparam int HOLD_CYCLES     = 2500;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int SHOWN_LIMIT     = 10;

    // One expected reading of the meter.
    typedef struct {
        logic signed [RESULT_W-1:0] filtered;
        logic signed [RESULT_W-1:0] raw;
        bit                         fault;
        bit                         refilled;
    } reading_t;

    // Tracks peaks and the average history, and checks readings in order.
    class meter_scoreboard;
        logic [REF_W-1:0]           reference_ohms;
        logic signed [SAMPLE_W-1:0] peak [3];
        logic signed [SAMPLE_W-1:0] trough [3];
        bit                         rearm [3];
        logic signed [RESULT_W-1:0] history [HIST_DEPTH];
        reading_t                   expected_readings [$];
        int                         errors;

        function new();
            reference_ohms = REF_RESET;
            for (int c = 0; c < 3; c++) begin
                peak[c]   = PEAK_START;
                trough[c] = TROUGH_START;
                rearm[c]  = 1'b0;
            end
            for (int i = 0; i < HIST_DEPTH; i++) history[i] = '0;
            errors = 0;
        endfunction

        function void set_reference(logic [REF_W-1:0] value);
            reference_ohms = value;
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= SHOWN_LIMIT) $display("Mismatch: %s", msg);
        endfunction

        function longint unsigned magnitude_of(longint v);
            return (v < 0) ? longint'(-v) : v;
        endfunction

        // Quotient of magnitudes rounded half away from zero.
        function longint round_half_away(longint unsigned num, longint unsigned den, bit neg);
            longint unsigned q;
            q = (num * 64'd2 / den + 64'd1) / 64'd2;
            return neg ? -longint'(q) : longint'(q);
        endfunction

        function logic signed [RESULT_W-1:0] clip32(longint v);
            if (v > longint'(SAT_MAX)) return SAT_MAX;
            if (v < longint'(SAT_MIN)) return SAT_MIN;
            return v[RESULT_W-1:0];
        endfunction

        // A large step, a zero or a sign change refills the whole history.
        function bit needs_refill(logic signed [RESULT_W-1:0] oldest,
                                  logic signed [RESULT_W-1:0] fresh);
            longint o, n;
            o = oldest;
            n = fresh;
            if (o == 0 || n == 0) return 1'b1;
            if (n > 0) return (o > STEP_RATIO * n) || (STEP_RATIO * o < n);
            return (o < STEP_RATIO * n) || (STEP_RATIO * o > n);
        endfunction

        // Notes one accepted sample; the end of an offset burst yields a reading.
        function void take_sample(logic signed [SAMPLE_W-1:0] smp,
                                  logic [CHAN_W-1:0] ch, logic is_last);
            longint amp_src, amp_cell, amp_off, num, den, total;
            longint unsigned scaled;
            reading_t r;
            if (ch > CH_OFFSET) return;
            if (rearm[ch]) begin
                peak[ch]   = PEAK_START;
                trough[ch] = TROUGH_START;
                rearm[ch]  = 1'b0;
            end
            if (smp > peak[ch]) peak[ch] = smp;
            if (smp < trough[ch]) trough[ch] = smp;
            if (is_last) rearm[ch] = 1'b1;
            if (!(is_last && ch == CH_OFFSET)) return;

            amp_src  = longint'(peak[CH_SOURCE]) - longint'(trough[CH_SOURCE]);
            amp_cell = longint'(peak[CH_CELL]) - longint'(trough[CH_CELL]);
            amp_off  = longint'(peak[CH_OFFSET]) - longint'(trough[CH_OFFSET]);
            num = amp_cell - amp_off;
            den = amp_src - amp_off;
            r.raw      = '0;
            r.fault    = 1'b0;
            r.refilled = 1'b0;

            if (den == 0) begin
                r.fault = 1'b1;
            end else begin
                scaled = (magnitude_of(num) * reference_ohms) << FRAC_BITS;
                r.raw = clip32(round_half_away(scaled, magnitude_of(den),
                                               ((num < 0) != (den < 0)) && scaled != 0));
                r.refilled = needs_refill(history[HIST_DEPTH-1], r.raw);
                if (r.refilled) begin
                    for (int i = 0; i < HIST_DEPTH; i++) history[i] = r.raw;
                end else begin
                    for (int i = HIST_DEPTH - 1; i > 0; i--) history[i] = history[i-1];
                    history[0] = r.raw;
                end
            end

            total = 0;
            for (int i = 0; i < HIST_DEPTH; i++) total += history[i];
            r.filtered = clip32(round_half_away(magnitude_of(total), 64'(HIST_DEPTH),
                                                total < 0));
            expected_readings.push_back(r);
        endfunction

        // Compares one accepted result with the oldest expected reading.
        function void check_reading(logic [63:0] data, logic [1:0] user);
            reading_t want;
            logic signed [RESULT_W-1:0] got_filtered, got_raw;
            got_filtered = data[31:0];
            got_raw      = data[63:32];
            if (expected_readings.size() == 0) begin
                flag($sformatf("result with none expected: filtered %0d raw %0d flags %b",
                               got_filtered, got_raw, user));
                return;
            end
            want = expected_readings.pop_front();
            if (got_filtered !== want.filtered)
                flag($sformatf("filtered_resistance expected %0d, got %0d",
                               want.filtered, got_filtered));
            if (got_raw !== want.raw)
                flag($sformatf("raw_resistance expected %0d, got %0d", want.raw, got_raw));
            if (user[0] !== want.fault)
                flag($sformatf("divide_fault expected %0d, got %b", want.fault, user[0]));
            if (user[1] !== want.refilled)
                flag($sformatf("history_refilled expected %0d, got %b",
                               want.refilled, user[1]));
        endfunction
    endclass

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;   // [15:0] sample
    logic [1:0]  s_tuser   = '0;   // [1:0] channel
    logic        s_tlast   = 1'b0; // end_of_burst
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [63:0] m_tdata;          // [31:0] filtered_resistance, [63:32] raw_resistance
    logic [1:0]  m_tuser;          // [0] divide_fault, [1] history_refilled
    logic        cfg_we    = 1'b0;
    logic [19:0] cfg_wdata = '0;

    meter_scoreboard sb;
    int  sender_idle_pct = 0;
    int  recv_stall_pct  = 0;
    bit  hold_request    = 1'b0;
    int  hold_left       = 0;
    bit  hold_taken      = 1'b0;
    int  items_sent      = 0;
    int  cycle_count     = 0;

    ratiometric_resistance_meter #(
        .AVERAGE_LENGTH (HIST_DEPTH),
        .FRACTION_BITS  (FRAC_BITS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Clock with a period of 10.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver: random stalls, plus one long hold-off on request.
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_tready = 1'b0;
        end else if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
            m_tready   = 1'b0;
        end else begin
            m_tready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Both channels are sampled at the rising edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) sb.check_reading(m_tdata, m_tuser);
            if (s_tvalid && s_tready) sb.take_sample(s_tdata, s_tuser, s_tlast);
        end
    end

    // Watchdog on the total run length.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Offers one item, with random idle cycles first; called at a falling edge.
    task automatic send_item(input logic signed [SAMPLE_W-1:0] smp,
                             input logic [CHAN_W-1:0] ch, input logic is_last);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = smp;
        s_tuser  = ch;
        s_tlast  = is_last;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        if (ch <= CH_OFFSET) items_sent++;
    endtask

    // A burst whose amplitude is exactly amp: both extremes, then inner points.
    task automatic send_burst(input logic [CHAN_W-1:0] ch, input int amp);
        int count, lo, val;
        bit low_first;
        count     = $urandom_range(6, 2);
        lo        = -32768 + $urandom_range(65535 - amp);
        low_first = 1'($urandom_range(1));
        for (int i = 0; i < count; i++) begin
            if (i == 0) val = low_first ? lo : lo + amp;
            else if (i == 1) val = low_first ? lo + amp : lo;
            else val = lo + $urandom_range(amp);
            send_item(val[15:0], ch, i == count - 1);
        end
    endtask

    function automatic int jitter(int amp);
        int j;
        j = amp * (97 + $urandom_range(6)) / 100;
        return (j > 65535) ? 65535 : j;
    endfunction

    // One measurement cycle of a scene; source or cell may be skipped or swapped.
    task automatic send_measurement(input int src_amp, input int cell_amp, input int off_amp);
        bit cell_first;
        cell_first = ($urandom_range(3) == 0);
        if (cell_first && $urandom_range(9) != 0) send_burst(CH_CELL, jitter(cell_amp));
        if ($urandom_range(9) != 0) send_burst(CH_SOURCE, jitter(src_amp));
        if (!cell_first && $urandom_range(9) != 0) send_burst(CH_CELL, jitter(cell_amp));
        send_burst(CH_OFFSET, jitter(off_amp));
    endtask

    // A few items of any channel, value and burst flag.
    task automatic send_noise();
        int count;
        logic [31:0] word;
        count = $urandom_range(4, 1);
        repeat (count) begin
            word = $urandom;
            send_item(word[15:0], word[17:16], word[20:19] == 2'd0);
        end
    endtask

    // Waits for every expected reading, then lets the block go quiet.
    task automatic drain();
        s_tvalid = 1'b0;
        while (sb.expected_readings.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reference(input logic [REF_W-1:0] value);
        cfg_wdata = value;
        cfg_we    = 1'b1;
        @(negedge aclk);
        cfg_we    = 1'b0;
        sb.set_reference(value);
    endtask

    function automatic logic [REF_W-1:0] reference_for_phase(int p);
        case (p)
            1: return 20'd1000000;
            2: return 20'd1;
            3: return 20'd0;
            4: return 20'hFFFFF;
            6: return REF_RESET;
            default: return REF_W'($urandom_range(1000000, 1));
        endcase
    endfunction

    initial begin
        int src_amp, cell_amp, off_amp, scene_left, target;
        sb = new();
        src_amp    = 0;
        cell_amp   = 0;
        off_amp    = 0;
        scene_left = 0;
        target     = 0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Offset burst alone: source and cell have never been seen.
        send_item(16'sd0, CH_OFFSET, 1'b1);
        // Full-scale source, and a cell at the most negative code.
        send_item(-16'sd32768, CH_SOURCE, 1'b0);
        send_item(16'sd32767, CH_SOURCE, 1'b1);
        send_item(-16'sd32768, CH_CELL, 1'b1);
        send_item(16'sd0, CH_OFFSET, 1'b1);
        // Source and offset amplitudes equal: zero divisor.
        send_item(16'sd100, CH_SOURCE, 1'b0);
        send_item(16'sd200, CH_SOURCE, 1'b1);
        send_item(16'sd50, CH_CELL, 1'b1);
        send_item(16'sd1000, CH_OFFSET, 1'b0);
        send_item(16'sd1100, CH_OFFSET, 1'b1);
        // The unused channel is ignored, even with the burst flag.
        send_item(16'sd1234, 2'd3, 1'b1);
        send_item(-16'sd1, 2'd3, 1'b0);
        // Cell below offset: negative ratio.
        send_item(16'sd0, CH_SOURCE, 1'b0);
        send_item(16'sd1000, CH_SOURCE, 1'b1);
        send_item(16'sd7, CH_CELL, 1'b1);
        send_item(16'sd0, CH_OFFSET, 1'b0);
        send_item(16'sd100, CH_OFFSET, 1'b1);
        // A plain ratio, then an offset burst of the same amplitude alone so the history shifts.
        send_item(16'sd0, CH_SOURCE, 1'b0);
        send_item(16'sd1000, CH_SOURCE, 1'b1);
        send_item(16'sd0, CH_CELL, 1'b0);
        send_item(16'sd500, CH_CELL, 1'b1);
        send_item(16'sd0, CH_OFFSET, 1'b0);
        send_item(16'sd100, CH_OFFSET, 1'b1);
        send_item(-16'sd50, CH_OFFSET, 1'b0);
        send_item(16'sd50, CH_OFFSET, 1'b1);

        // Random phases over reference values and stall patterns.
        for (int p = 0; p < PHASE_COUNT; p++) begin
            if (p != 0) begin
                drain();
                write_reference(reference_for_phase(p));
            end
            sender_idle_pct = (p % 4 == 1) ? 78 : (p % 4 == 3) ? 28 : 0;
            recv_stall_pct  = (p % 4 == 2) ? 78 : (p % 4 == 3) ? 28 : 0;
            if (p == 4) hold_request = 1'b1;
            target = items_sent + ITEMS_PER_PHASE;
            while (items_sent < target) begin
                if ($urandom_range(9) < 2) begin
                    send_noise();
                end else begin
                    if (scene_left == 0) begin
                        scene_left = $urandom_range(8, 2);
                        off_amp    = $urandom_range(400);
                        src_amp    = $urandom_range(60000, 800);
                        if ($urandom_range(7) == 0) cell_amp = $urandom_range(off_amp);
                        else cell_amp = $urandom_range(60000, off_amp + 1);
                    end
                    send_measurement(src_amp, cell_amp, off_amp);
                    scene_left--;
                end
            end
        end
        drain();

        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
